// ----- rtl/frae_pkg.sv -----
package frae_pkg;

  localparam int OP_W = 4;
  localparam int ST_W = 2;
  localparam int UA_W = 5;

  localparam logic [OP_W-1:0] OP_LDC = 4'd0;
  localparam logic [OP_W-1:0] OP_MOV = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB = 4'd3;
  localparam logic [OP_W-1:0] OP_MUL = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV = 4'd5;
  localparam logic [OP_W-1:0] OP_AND = 4'd6;
  localparam logic [OP_W-1:0] OP_OR  = 4'd7;
  localparam logic [OP_W-1:0] OP_XOR = 4'd8;
  localparam logic [OP_W-1:0] OP_NEG = 4'd9;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV0   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNDEF  = 2'd2;
  localparam logic [ST_W-1:0] ST_BADREG = 2'd3;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_A    = 2'd1;
  localparam logic [1:0] RD_B    = 2'd2;

  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_A_CON = 2'd1;
  localparam logic [1:0] WR_B_RES = 2'd2;
  localparam logic [1:0] WR_A_NEG = 2'd3;

  localparam logic [1:0] RES_KEEP = 2'd0;
  localparam logic [1:0] RES_ALU  = 2'd1;
  localparam logic [1:0] RES_ACC  = 2'd2;
  localparam logic [1:0] RES_QUOT = 2'd3;

  localparam logic [2:0] EX_NONE     = 3'd0;
  localparam logic [2:0] EX_MUL_INIT = 3'd1;
  localparam logic [2:0] EX_MUL_STEP = 3'd2;
  localparam logic [2:0] EX_DIV_INIT = 3'd3;
  localparam logic [2:0] EX_DIV_STEP = 3'd4;

  localparam logic [2:0] J_GOTO  = 3'd0;
  localparam logic [2:0] J_FETCH = 3'd1;
  localparam logic [2:0] J_DISP  = 3'd2;
  localparam logic [2:0] J_LOOP  = 3'd3;
  localparam logic [2:0] J_DIVZ  = 3'd4;
  localparam logic [2:0] J_EMIT  = 3'd5;

  localparam logic [UA_W-1:0] A_FETCH  = 5'd0;
  localparam logic [UA_W-1:0] A_EMIT   = 5'd1;
  localparam logic [UA_W-1:0] A_OP0    = 5'd2;
  localparam logic [UA_W-1:0] A_RDA    = 5'd3;
  localparam logic [UA_W-1:0] A_RDB    = 5'd4;
  localparam logic [UA_W-1:0] A_ALU    = 5'd5;
  localparam logic [UA_W-1:0] A_WRB    = 5'd6;
  localparam logic [UA_W-1:0] A_NEG    = 5'd7;
  localparam logic [UA_W-1:0] A_NEG_WB = 5'd8;
  localparam logic [UA_W-1:0] A_NEG_WA = 5'd9;
  localparam logic [UA_W-1:0] A_MUL    = 5'd10;
  localparam logic [UA_W-1:0] A_MUL_LP = 5'd11;
  localparam logic [UA_W-1:0] A_MUL_WR = 5'd12;
  localparam logic [UA_W-1:0] A_DIVZ   = 5'd13;
  localparam logic [UA_W-1:0] A_DIV    = 5'd14;
  localparam logic [UA_W-1:0] A_DIV_LP = 5'd15;
  localparam logic [UA_W-1:0] A_DIV_WR = 5'd16;

  typedef struct packed {
    logic [1:0]      rd;
    logic [1:0]      wr;
    logic [1:0]      res;
    logic [2:0]      ex;
    logic [2:0]      jmp;
    logic [UA_W-1:0] nxt;
  } uc_word_t;

  typedef struct packed {
    logic            accept;
    logic            err;
    logic [OP_W-1:0] op;
    logic            cnt_zero;
    logic            va_zero;
    logic            out_free;
  } seq_in_t;

  function automatic uc_word_t uc_rom(input logic [UA_W-1:0] addr);
    uc_word_t w;
    w = '{RD_NONE, WR_NONE, RES_KEEP, EX_NONE, J_FETCH, A_RDA};
    case (addr)
      A_FETCH:  w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_NONE,     J_FETCH, A_RDA};
      A_EMIT:   w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_NONE,     J_EMIT,  A_FETCH};
      A_OP0:    w = '{RD_NONE, WR_A_CON, RES_KEEP, EX_NONE,     J_GOTO,  A_EMIT};
      A_RDA:    w = '{RD_A,    WR_NONE,  RES_KEEP, EX_NONE,     J_GOTO,  A_RDB};
      A_RDB:    w = '{RD_B,    WR_NONE,  RES_KEEP, EX_NONE,     J_DISP,  A_EMIT};
      A_ALU:    w = '{RD_NONE, WR_NONE,  RES_ALU,  EX_NONE,     J_GOTO,  A_WRB};
      A_WRB:    w = '{RD_NONE, WR_B_RES, RES_KEEP, EX_NONE,     J_GOTO,  A_EMIT};
      A_NEG:    w = '{RD_NONE, WR_NONE,  RES_ALU,  EX_NONE,     J_GOTO,  A_NEG_WB};
      A_NEG_WB: w = '{RD_NONE, WR_B_RES, RES_KEEP, EX_NONE,     J_GOTO,  A_NEG_WA};
      A_NEG_WA: w = '{RD_NONE, WR_A_NEG, RES_KEEP, EX_NONE,     J_GOTO,  A_EMIT};
      A_MUL:    w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_MUL_INIT, J_GOTO,  A_MUL_LP};
      A_MUL_LP: w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_MUL_STEP, J_LOOP,  A_MUL_WR};
      A_MUL_WR: w = '{RD_NONE, WR_NONE,  RES_ACC,  EX_NONE,     J_GOTO,  A_WRB};
      A_DIVZ:   w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_NONE,     J_DIVZ,  A_EMIT};
      A_DIV:    w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_DIV_INIT, J_GOTO,  A_DIV_LP};
      A_DIV_LP: w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_DIV_STEP, J_LOOP,  A_DIV_WR};
      A_DIV_WR: w = '{RD_NONE, WR_NONE,  RES_QUOT, EX_NONE,     J_GOTO,  A_WRB};
      default:  w = '{RD_NONE, WR_NONE,  RES_KEEP, EX_NONE,     J_FETCH, A_RDA};
    endcase
    return w;
  endfunction

  function automatic logic [UA_W-1:0] uc_dispatch(input logic [OP_W-1:0] op);
    logic [UA_W-1:0] a;
    a = A_EMIT;
    case (op)
      OP_MOV, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: a = A_ALU;
      OP_NEG:  a = A_NEG;
      OP_MUL:  a = A_MUL;
      OP_DIV:  a = A_DIVZ;
      default: a = A_EMIT;
    endcase
    return a;
  endfunction

endpackage

// ----- rtl/frae_seq.sv -----
module frae_seq
  import frae_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  seq_in_t  si,
  output uc_word_t uc
);

  logic [UA_W-1:0] upc;
  logic [UA_W-1:0] upc_next;

  assign uc = uc_rom(upc);

  always_comb begin
    upc_next = upc;
    case (uc.jmp)
      J_GOTO: upc_next = uc.nxt;
      J_FETCH: begin
        if (si.accept) begin
          if (si.err) begin
            upc_next = A_EMIT;
          end else if (si.op == OP_LDC) begin
            upc_next = A_OP0;
          end else begin
            upc_next = uc.nxt;
          end
        end
      end
      J_DISP: upc_next = uc_dispatch(si.op);
      J_LOOP: upc_next = si.cnt_zero ? uc.nxt : upc;
      J_DIVZ: upc_next = si.va_zero ? uc.nxt : upc + 1'b1;
      J_EMIT: upc_next = si.out_free ? uc.nxt : upc;
      default: upc_next = A_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= A_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ----- rtl/four_register_alu_executor_top.sv -----
// An error goes straight to emit and a load writes its constant before emit. Other
// instructions read both registers: a divide by zero then emits at once, move, add,
// subtract and logic go through the ALU, the swap-negate writes both registers, and
// multiply and divide run a serial loop before the write. The next transfer can be
// taken as the result is presented, and a stalled result holds the next instruction in emit.
// Reset clears the register file, the microcode address and the output valid.
module four_register_alu_executor_top
  import frae_pkg::*;
#(
  parameter int NUM_REGS   = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,  // op[3:0], reg_a[7:4], operand_b[11:8]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata   // status[1:0], reg0..reg3_value[129:2], 32 bits each
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] CNT_INIT = CW'(DW - 1);
  localparam logic [4:0] NR = 5'(NUM_REGS);

  logic [DW-1:0] rf [NUM_REGS];
  logic [DW-1:0] va;
  logic [DW-1:0] vb;
  logic [DW-1:0] acc;
  logic [DW-1:0] q;
  logic [DW-1:0] res;
  logic [CW-1:0] cnt;
  logic          sgn;
  logic [OP_W-1:0] op_r;
  logic [3:0]    ia_r;
  logic [3:0]    ib_r;
  logic [ST_W-1:0] st;

  logic [OP_W-1:0] op_in;
  logic [3:0]    ia_in;
  logic [3:0]    ib_in;
  logic [ST_W-1:0] st_in;
  logic          accept;
  logic          out_free;
  logic [DW-1:0] alu;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic [31:0]   rv [4];

  seq_in_t  si;
  uc_word_t uc;

  function automatic logic [DW-1:0] sext8(input logic [DW-1:0] x);
    return {{(DW-8){x[7]}}, x[7:0]};
  endfunction

  function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
    return x[DW-1] ? (~x + 1'b1) : x;
  endfunction

  assign op_in = s_tdata[3:0];
  assign ia_in = s_tdata[7:4];
  assign ib_in = s_tdata[11:8];

  always_comb begin
    if (op_in > OP_NEG) begin
      st_in = ST_UNDEF;
    end else if ({1'b0, ia_in} >= NR || (op_in != OP_LDC && {1'b0, ib_in} >= NR)) begin
      st_in = ST_BADREG;
    end else begin
      st_in = ST_OK;
    end
  end

  assign s_tready = (uc.jmp == J_FETCH);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign si.accept   = accept;
  assign si.err      = (st_in != ST_OK);
  assign si.op       = accept ? op_in : op_r;
  assign si.cnt_zero = (cnt == '0);
  assign si.va_zero  = (va == '0);
  assign si.out_free = out_free;

  frae_seq u_seq (
    .clk (clk),
    .rst (rst),
    .si  (si),
    .uc  (uc)
  );

  always_comb begin
    case (op_r)
      OP_ADD:  alu = vb + va;
      OP_SUB:  alu = vb - va;
      OP_AND:  alu = sext8(va & vb);
      OP_OR:   alu = sext8(va | vb);
      OP_XOR:  alu = va ^ vb;
      default: alu = va;
    endcase
  end

  assign rem_sh = {acc, q[DW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, va};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= op_in;
      ia_r <= ia_in;
      ib_r <= ib_in;
      st   <= st_in;
    end
    if (uc.jmp == J_DIVZ && va == '0) begin
      st <= ST_DIV0;
    end

    case (uc.rd)
      RD_A:    va <= rf[ia_r[AW-1:0]];
      RD_B:    vb <= rf[ib_r[AW-1:0]];
      default: ;
    endcase

    case (uc.ex)
      EX_MUL_INIT: begin
        acc <= '0;
        q   <= va;
        cnt <= CNT_INIT;
      end
      EX_MUL_STEP: begin
        acc <= q[0] ? acc + vb : acc;
        vb  <= vb << 1;
        q   <= q >> 1;
        cnt <= cnt - 1'b1;
      end
      EX_DIV_INIT: begin
        acc <= '0;
        q   <= mag(vb);
        va  <= mag(va);
        sgn <= va[DW-1] ^ vb[DW-1];
        cnt <= CNT_INIT;
      end
      EX_DIV_STEP: begin
        if (!diff[DW+1]) begin
          acc <= diff[DW-1:0];
          q   <= {q[DW-2:0], 1'b1};
        end else begin
          acc <= rem_sh[DW-1:0];
          q   <= {q[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
      end
      default: ;
    endcase

    case (uc.res)
      RES_ALU:  res <= alu;
      RES_ACC:  res <= acc;
      RES_QUOT: res <= sgn ? (~q + 1'b1) : q;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        rf[i] <= '0;
      end
    end else begin
      case (uc.wr)
        WR_A_CON: rf[ia_r[AW-1:0]] <= {{(DW-4){1'b0}}, ib_r};
        WR_B_RES: rf[ib_r[AW-1:0]] <= res;
        WR_A_NEG: rf[ia_r[AW-1:0]] <= ~va + 1'b1;
        default:  ;
      endcase
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_out
    if (j < NUM_REGS) begin : g_reg
      if (DW >= 32) begin : g_wide
        assign rv[j] = rf[j][31:0];
      end else begin : g_narrow
        assign rv[j] = {{(32-DW){1'b0}}, rf[j]};
      end
    end else begin : g_none
      assign rv[j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (uc.jmp == J_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uc.jmp == J_EMIT && out_free) begin
      m_tdata <= {6'b0, rv[3], rv[2], rv[1], rv[0], st};
    end
  end

endmodule
